// File: rtl/vdd_pkg.sv
// Shared types and constants of the LEB128 varint decoder and deframer.
// Used by the front decoder, the result queue and the top level.
`timescale 1ns / 1ps
package vdd_pkg;

   localparam logic [1:0] MODE_V32 = 2'd0;
   localparam logic [1:0] MODE_V64 = 2'd1;
   localparam logic [1:0] MODE_LEN = 2'd2;

   localparam logic [1:0] KIND_VALUE    = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD  = 2'd1;
   localparam logic [1:0] KIND_TRUNC    = 2'd2;
   localparam logic [1:0] KIND_OVERLONG = 2'd3;

   localparam logic [3:0] LIMIT_NARROW = 4'd5;
   localparam logic [3:0] LIMIT_WIDE   = 4'd10;
   localparam logic [3:0] LAST_SHIFT_COUNT = 4'd9;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = QPTR_W + 1;

   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_MODE = 1'b0;

   typedef enum logic [2:0] {
      PH_VARINT  = 3'b001,
      PH_PAYLOAD = 3'b010,
      PH_SKIP    = 3'b100
   } phase_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] value;
      logic        last;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type r0;
      result_type r1;
   } push_type;

endpackage

// File: rtl/vdd_front.sv
// Front decoder: accepts bytes, runs the varint and payload state, and
// pushes zero, one or two results per request. Depends on vdd_pkg.
`timescale 1ns / 1ps
module vdd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic [1:0]        mode,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [7:0]        in_byte,
   input  logic              in_end,
   input  logic              space_ok,
   output vdd_pkg::push_type push
);

   logic [63:0]        acc_ff, acc_in;
   logic [3:0]         cnt_ff, cnt_in;
   vdd_pkg::phase_type phase_ff, phase_in;
   logic [31:0]        rem_ff, rem_in;

   logic        accept;
   logic        wide;
   logic [3:0]  limit;
   logic [6:0]  shift;
   logic [63:0] shifted;
   logic [63:0] acc_new;
   logic [3:0]  cnt_inc;
   logic        pay_last;

   assign in_ready = space_ok;
   assign accept   = in_valid & space_ok;
   assign wide     = (mode == vdd_pkg::MODE_V64);
   assign limit    = wide ? vdd_pkg::LIMIT_WIDE : vdd_pkg::LIMIT_NARROW;
   assign shift    = ({3'b000, cnt_ff} << 3) - {3'b000, cnt_ff};
   assign cnt_inc  = cnt_ff + 4'd1;
   assign pay_last = (rem_ff <= 32'd1);

   always_comb begin
      shifted = '0;
      if (cnt_ff <= vdd_pkg::LAST_SHIFT_COUNT) begin
         shifted = {57'd0, in_byte[6:0]} << shift;
      end
      acc_new = acc_ff | shifted;
      if (!wide) begin
         acc_new[63:32] = 32'd0;
      end
   end

   always_comb begin
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      phase_in = phase_ff;
      rem_in   = rem_ff;
      push     = '0;
      if (accept) begin
         case (phase_ff)
            vdd_pkg::PH_SKIP: begin
               if (in_end) begin
                  acc_in   = '0;
                  cnt_in   = '0;
                  phase_in = vdd_pkg::PH_VARINT;
               end
            end
            vdd_pkg::PH_PAYLOAD: begin
               push.count    = 2'd1;
               push.r0.kind  = vdd_pkg::KIND_PAYLOAD;
               push.r0.value = {56'd0, in_byte};
               push.r0.last  = pay_last;
               if (pay_last) begin
                  rem_in   = '0;
                  acc_in   = '0;
                  cnt_in   = '0;
                  phase_in = vdd_pkg::PH_VARINT;
               end else begin
                  rem_in = rem_ff - 32'd1;
                  if (in_end) begin
                     push.count   = 2'd2;
                     push.r1.kind = vdd_pkg::KIND_TRUNC;
                     rem_in       = '0;
                     acc_in       = '0;
                     cnt_in       = '0;
                     phase_in     = vdd_pkg::PH_VARINT;
                  end
               end
            end
            default: begin
               if (!in_byte[7]) begin
                  push.count    = 2'd1;
                  push.r0.kind  = vdd_pkg::KIND_VALUE;
                  push.r0.value = acc_new;
                  acc_in        = '0;
                  cnt_in        = '0;
                  phase_in      = vdd_pkg::PH_VARINT;
                  if ((mode == vdd_pkg::MODE_LEN) && (acc_new != 64'd0)) begin
                     if (in_end) begin
                        push.count   = 2'd2;
                        push.r1.kind = vdd_pkg::KIND_TRUNC;
                     end else begin
                        rem_in   = acc_new[31:0];
                        phase_in = vdd_pkg::PH_PAYLOAD;
                     end
                  end
               end else if ((cnt_inc >= limit) || (cnt_inc == 4'd0)) begin
                  push.count   = 2'd1;
                  push.r0.kind = vdd_pkg::KIND_OVERLONG;
                  acc_in       = '0;
                  cnt_in       = '0;
                  phase_in     = in_end ? vdd_pkg::PH_VARINT : vdd_pkg::PH_SKIP;
               end else if (in_end) begin
                  push.count   = 2'd1;
                  push.r0.kind = vdd_pkg::KIND_TRUNC;
                  acc_in       = '0;
                  cnt_in       = '0;
                  phase_in     = vdd_pkg::PH_VARINT;
               end else begin
                  acc_in = acc_new;
                  cnt_in = cnt_inc;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         cnt_ff   <= '0;
         phase_ff <= vdd_pkg::PH_VARINT;
         rem_ff   <= '0;
      end else begin
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         phase_ff <= phase_in;
         rem_ff   <= rem_in;
      end
   end

endmodule

// File: rtl/vdd_queue.sv
// Result queue: takes up to two results per cycle from the front decoder
// and hands them out one at a time. Depends on vdd_pkg.
`timescale 1ns / 1ps
module vdd_queue (
   input  logic                clock,
   input  logic                reset,
   input  vdd_pkg::push_type   push,
   output logic                space_ok,
   output logic                out_valid,
   input  logic                out_ready,
   output vdd_pkg::result_type out_item
);

   vdd_pkg::result_type        q_ff [vdd_pkg::QUEUE_DEPTH];
   logic [vdd_pkg::QPTR_W-1:0] wr_ff, wr_in;
   logic [vdd_pkg::QPTR_W-1:0] rd_ff, rd_in;
   logic [vdd_pkg::QCNT_W-1:0] cnt_ff, cnt_in;
   logic [vdd_pkg::QPTR_W-1:0] wr_next;
   logic                       pop;

   assign out_valid = (cnt_ff != '0);
   assign out_item  = q_ff[rd_ff];
   assign pop       = out_valid & out_ready;
   assign space_ok  = (cnt_ff <= vdd_pkg::QCNT_W'(vdd_pkg::QUEUE_DEPTH - 2));
   assign wr_next   = wr_ff + vdd_pkg::QPTR_W'(1);

   always_comb begin
      wr_in  = wr_ff + vdd_pkg::QPTR_W'(push.count);
      rd_in  = pop ? rd_ff + vdd_pkg::QPTR_W'(1) : rd_ff;
      cnt_in = cnt_ff + vdd_pkg::QCNT_W'(push.count) - vdd_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         q_ff[wr_ff] <= push.r0;
      end
      if (push.count == 2'd2) begin
         q_ff[wr_next] <= push.r1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// File: rtl/varint_decoder_deframer_core.sv
// Top level of the LEB128 varint decoder and length-prefixed deframer.
// Holds the mode register and joins vdd_front to vdd_queue; uses vdd_pkg.
//
//   Group  Direction  Contents
//   req    in         tdata[7:0] data_byte, tlast buffer_end
//   rsp    out        tdata[63:0] decoded_value, tuser[1:0] result_kind,
//                     tlast payload_last
//   csr    in/out     APB, decode_mode at byte address 0
//
// One request is taken per cycle while the queue has room; a request that yields
// two results hands them out one at a time. Results pass through a four-entry queue, so a request
// is taken whenever at least two entries are free. Reset clears the decode
// state, the queue and decode_mode. A stalled output backs up the queue and
// then lowers req_tready; the decoder itself never stalls.
`timescale 1ns / 1ps
module varint_decoder_deframer_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,   // [7:0] data_byte
   input  logic                             req_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [63:0]                      rsp_tdata,   // [63:0] decoded_value
   output logic [1:0]                       rsp_tuser,   // [1:0] result_kind
   output logic                             rsp_tlast,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [vdd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);

   logic [1:0]          mode_ff, mode_in;
   logic                csr_wr;
   logic                space_ok;
   vdd_pkg::push_type   push;
   vdd_pkg::result_type out_item;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = (csr_paddr[2] == vdd_pkg::CSR_IDX_MODE) ? {30'd0, mode_ff} : 32'd0;

   always_comb begin
      mode_in = mode_ff;
      if (csr_wr && (csr_paddr[2] == vdd_pkg::CSR_IDX_MODE)) begin
         mode_in = csr_pwdata[1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= vdd_pkg::MODE_V32;
      end else begin
         mode_ff <= mode_in;
      end
   end

   vdd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .mode     (mode_ff),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_byte  (req_tdata),
      .in_end   (req_tlast),
      .space_ok (space_ok),
      .push     (push)
   );

   vdd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space_ok  (space_ok),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item)
   );

   assign rsp_tdata = out_item.value;
   assign rsp_tuser = out_item.kind;
   assign rsp_tlast = out_item.last;

endmodule

// File: tb/sv/varint_decoder_deframer_core_tb.sv
// Self-checking testbench for varint_decoder_deframer_core: byte requests in all decode modes,
// with an internal predictor of the LEB128 decoder and deframer and random stalls on both sides.
// Depends on vdd_pkg and the RTL of the core only.
`timescale 1ns / 1ps
module varint_decoder_deframer_core_tb;

   localparam int unsigned CYCLE_LIMIT = 300000;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_COUNT = 10;
   localparam int PHASE_BYTES = 155;
   localparam logic [vdd_pkg::CSR_ADDR_W-1:0] MODE_ADDR = {vdd_pkg::CSR_IDX_MODE, 2'b00};

   typedef struct packed {
      logic [7:0] data;
      logic       eob;
   } byte_req_type;

   logic clock = 1'b0;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [7:0] req_tdata;   // [7:0] data_byte
   logic req_tlast;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [63:0] rsp_tdata;  // [63:0] decoded_value
   logic [1:0] rsp_tuser;   // [1:0] result_kind
   logic rsp_tlast;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [vdd_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic csr_pready;

   byte_req_type pending_bytes[$];
   vdd_pkg::result_type awaited_results[$];
   int queued = 0;
   int issued = 0;
   int accepted = 0;
   int mismatch_count = 0;
   int unsigned cycle_count = 0;
   int unsigned gap_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned req_gap = 0;
   int unsigned rsp_hold = 0;
   logic req_fire = 1'b0;

   logic [1:0] cfg_mode = vdd_pkg::MODE_V32;
   logic [63:0] acc = '0;
   logic [3:0] nbytes = '0;
   vdd_pkg::phase_type dec_phase = vdd_pkg::PH_VARINT;
   logic [31:0] pay_left = '0;

   varint_decoder_deframer_core dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void push_result(logic [1:0] kind, logic [63:0] value, logic last);
      vdd_pkg::result_type r;
      r.kind = kind;
      r.value = value;
      r.last = last;
      awaited_results.push_back(r);
   endfunction

   function automatic void restart_item();
      acc = '0;
      nbytes = '0;
      dec_phase = vdd_pkg::PH_VARINT;
   endfunction

   function automatic void decode_byte(logic [7:0] b, logic eob);
      logic wide;
      logic [3:0] limit;
      logic [63:0] v;
      wide = (cfg_mode == vdd_pkg::MODE_V64);
      limit = wide ? vdd_pkg::LIMIT_WIDE : vdd_pkg::LIMIT_NARROW;
      case (dec_phase)
         vdd_pkg::PH_SKIP: begin
            if (eob) restart_item();
         end
         vdd_pkg::PH_PAYLOAD: begin
            if (pay_left <= 32'd1) begin
               push_result(vdd_pkg::KIND_PAYLOAD, {56'd0, b}, 1'b1);
               pay_left = '0;
               restart_item();
            end else begin
               push_result(vdd_pkg::KIND_PAYLOAD, {56'd0, b}, 1'b0);
               pay_left = pay_left - 32'd1;
               if (eob) begin
                  push_result(vdd_pkg::KIND_TRUNC, 64'd0, 1'b0);
                  pay_left = '0;
                  restart_item();
               end
            end
         end
         default: begin
            if (int'(nbytes) * 7 < 64) acc = acc | ({57'd0, b[6:0]} << (int'(nbytes) * 7));
            if (!wide) acc[63:32] = '0;
            if (!b[7]) begin
               v = acc;
               restart_item();
               push_result(vdd_pkg::KIND_VALUE, v, 1'b0);
               if (cfg_mode == vdd_pkg::MODE_LEN && v != 64'd0) begin
                  if (eob) push_result(vdd_pkg::KIND_TRUNC, 64'd0, 1'b0);
                  else begin
                     pay_left = v[31:0];
                     dec_phase = vdd_pkg::PH_PAYLOAD;
                  end
               end
            end else begin
               nbytes = nbytes + 4'd1;
               if (nbytes >= limit || nbytes == 4'd0) begin
                  push_result(vdd_pkg::KIND_OVERLONG, 64'd0, 1'b0);
                  restart_item();
                  if (!eob) dec_phase = vdd_pkg::PH_SKIP;
               end else if (eob) begin
                  push_result(vdd_pkg::KIND_TRUNC, 64'd0, 1'b0);
                  restart_item();
               end
            end
         end
      endcase
   endfunction

   always @(posedge clock) begin : watch
      vdd_pkg::result_type want;
      req_fire = !reset && req_tvalid && req_tready;
      if (req_fire) begin
         accepted++;
         decode_byte(req_tdata, req_tlast);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_results.size() == 0) begin
            mismatch_count++;
            $error("unexpected result: result_kind %0d decoded_value %h payload_last %b",
                   rsp_tuser, rsp_tdata, rsp_tlast);
         end else begin
            want = awaited_results.pop_front();
            if (rsp_tuser !== want.kind) begin
               mismatch_count++;
               $error("result_kind: expected %0d, got %0d", want.kind, rsp_tuser);
            end
            if (rsp_tdata !== want.value) begin
               mismatch_count++;
               $error("decoded_value: expected %h, got %h", want.value, rsp_tdata);
            end
            if (rsp_tlast !== want.last) begin
               mismatch_count++;
               $error("payload_last: expected %b, got %b", want.last, rsp_tlast);
            end
         end
      end
   end

   always @(negedge clock) begin : drive_req
      byte_req_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_bytes.size() != 0 && $urandom_range(99) < gap_pct) begin
            req_gap = $urandom_range(18);
            req_tvalid <= 1'b0;
         end else if (pending_bytes.size() != 0) begin
            nxt = pending_bytes.pop_front();
            issued++;
            req_tvalid <= 1'b1;
            req_tdata <= nxt.data;
            req_tlast <= nxt.eob;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(99) < stall_pct) begin
         rsp_hold = $urandom_range(18);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic logic [7:0] rand_byte();
      logic [31:0] r;
      r = $urandom;
      return r[7:0];
   endfunction

   function automatic int pad_count();
      return ($urandom_range(7) == 0) ? int'($urandom_range(2, 1)) : 0;
   endfunction

   function automatic void add_byte(logic [7:0] b, logic eob);
      byte_req_type item;
      item.data = b;
      item.eob = eob;
      pending_bytes.push_back(item);
      queued++;
   endfunction

   function automatic void add_varint(logic [63:0] v, int extra, logic eob);
      int n;
      logic [63:0] rest;
      n = 1;
      rest = v >> 7;
      while (rest != 64'd0) begin
         n++;
         rest = rest >> 7;
      end
      n = n + extra;
      for (int i = 0; i < n; i++) begin
         rest = v >> (7 * i);
         add_byte({i < n - 1, rest[6:0]}, eob && (i == n - 1));
      end
   endfunction

   function automatic void add_record(logic [1:0] mode);
      int lim;
      int pick;
      int n;
      int k;
      int w;
      logic [63:0] v;
      logic [31:0] hi;
      logic [31:0] lo;
      lim = (mode == vdd_pkg::MODE_V64) ? 10 : 5;
      pick = $urandom_range(99);
      if (mode == vdd_pkg::MODE_LEN && pick < 70) begin
         n = ($urandom_range(7) == 0) ? int'($urandom_range(40)) : int'($urandom_range(6));
         v = 64'(n);
         add_varint(v, pad_count(), 1'b0);
         for (int i = 0; i < n; i++)
            add_byte(rand_byte(), i == n - 1 && $urandom_range(3) == 0);
      end else if (mode == vdd_pkg::MODE_LEN && pick < 76) begin
         lo = $urandom;
         v = {32'd0, lo};
         n = $urandom_range(5, 1);
         add_varint(v, 0, 1'b0);
         for (int i = 0; i < n; i++) add_byte(rand_byte(), i == n - 1);
      end else if (mode == vdd_pkg::MODE_LEN && pick < 84) begin
         n = $urandom_range(12, 2);
         k = $urandom_range(n - 1);
         v = 64'(n);
         add_varint(v, 0, k == 0);
         for (int i = 0; i < k; i++) add_byte(rand_byte(), i == k - 1);
      end else if (mode != vdd_pkg::MODE_LEN && pick < 76) begin
         w = $urandom_range((mode == vdd_pkg::MODE_V64) ? 64 : 35);
         hi = $urandom;
         lo = $urandom;
         v = {hi, lo};
         if (w < 64) v = v & ((64'd1 << w) - 64'd1);
         add_varint(v, pad_count(), $urandom_range(3) == 0);
      end else if (pick < 90) begin
         k = ($urandom_range(3) == 0) ? 1 : 0;
         for (int i = 0; i < lim; i++)
            add_byte(rand_byte() | 8'h80, i == lim - 1 && k == 1);
         if (k == 0) begin
            n = $urandom_range(3);
            for (int i = 0; i < n; i++) add_byte(rand_byte(), 1'b0);
            add_byte(rand_byte(), 1'b1);
         end
      end else if (pick < 95) begin
         n = $urandom_range(lim - 1, 1);
         for (int i = 0; i < n; i++) add_byte(rand_byte() | 8'h80, i == n - 1);
      end else begin
         n = $urandom_range(4, 1);
         for (int i = 0; i < n; i++) add_byte(rand_byte(), $urandom_range(2) == 0);
      end
   endfunction

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_bytes.size() != 0 || issued != accepted || awaited_results.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_mode(input logic [1:0] mode);
      logic [31:0] wdata;
      wdata = $urandom;
      wdata[1:0] = mode;
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= MODE_ADDR;
      csr_pwdata <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      cfg_mode = mode;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== {30'd0, mode}) begin
         mismatch_count++;
         $error("decode_mode: expected %0d, got %0d", mode, csr_prdata);
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   initial begin
      int start;
      int n;
      int sel;
      logic [1:0] mode;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      rsp_tready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_mode(vdd_pkg::MODE_V32);
      add_varint(64'h7_FFFF_FFFF, 0, 1'b0);
      for (int i = 0; i < 5; i++) add_byte(8'h80, i == 4);
      add_byte(8'h81, 1'b1);
      for (int i = 0; i < 3; i++) add_byte(8'hFF, 1'b0);
      wait_idle();
      write_mode(vdd_pkg::MODE_V64);
      for (int i = 0; i < 6; i++) add_byte(8'hFF, 1'b0);
      add_byte(8'h01, 1'b0);
      wait_idle();
      write_mode(vdd_pkg::MODE_LEN);
      add_varint(64'd3, 0, 1'b0);
      add_byte(8'hAA, 1'b0);
      add_byte(8'hBB, 1'b0);
      add_byte(8'hCC, 1'b1);
      add_varint(64'd0, 0, 1'b0);
      add_varint(64'd5, 0, 1'b0);
      add_byte(8'h11, 1'b1);
      add_varint(64'd2, 0, 1'b1);

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         wait_idle();
         sel = (ph * 3 + 1) % 4;
         mode = sel[1:0];
         write_mode(mode);
         gap_pct = (ph == PHASE_COUNT - 1 || ph % 3 == 1) ? 0 : $urandom_range(30, 5);
         stall_pct = (ph == PHASE_COUNT - 1 || ph % 4 == 2) ? 0 : $urandom_range(20, 3);
         start = queued;
         while (queued - start < PHASE_BYTES) add_record(mode);
         if (ph != PHASE_COUNT - 1 && $urandom_range(1) == 1) begin
            n = $urandom_range(9, 1);
            for (int i = 0; i < n; i++) add_byte(rand_byte() | 8'h80, 1'b0);
         end
      end
      wait_idle();

      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/vdd_pkg.sv
rtl/vdd_front.sv
rtl/vdd_queue.sv
rtl/varint_decoder_deframer_core.sv
tb/sv/varint_decoder_deframer_core_tb.sv
